// ===== hdl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int NUM_KEYS    = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 2;
  localparam int DEB_W       = 8;
  localparam int LONG_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd20;
  localparam logic [LONG_W-1:0] LONG_RESET     = 16'd1000;

  // input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [KEY_W-1:0]       key_idx_t;

  // per-key command derived from the registered input item
  typedef struct packed {
    logic tick;
    logic edge_hit;
    logic level;
  } key_cmd_t;

  // per-key classification result
  typedef struct packed {
    logic emit;
    logic is_long;
  } key_res_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

// ===== hdl/bdpc_key.sv =====
// ----------------------------------------------------------------------------
// bdpc_key
// State and update logic for one button: debounce, hold timer, long flag.
// ----------------------------------------------------------------------------
module bdpc_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  bdpc_pkg::key_cmd_t          cmd,
  input  logic [bdpc_pkg::DEB_W-1:0]  debounce_ms,
  input  logic [bdpc_pkg::LONG_W-1:0] long_ms,
  output bdpc_pkg::key_res_t          res
);
  import bdpc_pkg::*;

  count_t since_edge, since_edge_next;
  count_t held_time, held_time_next;
  logic   timer_running, timer_running_next;
  logic   long_flag, long_flag_next;
  logic   last_level, last_level_next;
  count_t held_inc;

  assign held_inc = sat_inc(held_time);

  always_comb begin
    since_edge_next    = since_edge;
    held_time_next     = held_time;
    timer_running_next = timer_running;
    long_flag_next     = long_flag;
    last_level_next    = last_level;
    res                = '0;
    if (cmd.tick) begin
      since_edge_next = sat_inc(since_edge);
      held_time_next  = held_inc;
      if (timer_running && (held_inc >= COUNT_WIDTH'(long_ms))) begin
        timer_running_next = 1'b0;
        if (!last_level) begin
          long_flag_next = 1'b1;
        end
      end
    end else if (cmd.edge_hit) begin
      last_level_next = cmd.level;
      // edges inside the debounce window only record the level
      if (since_edge >= COUNT_WIDTH'(debounce_ms)) begin
        since_edge_next = '0;
        if (!cmd.level) begin
          held_time_next     = '0;
          long_flag_next     = 1'b0;
          timer_running_next = 1'b1;
        end else begin
          timer_running_next = 1'b0;
          res.is_long = long_flag;
          res.emit    = long_flag || (held_time < COUNT_WIDTH'(long_ms));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_edge    <= '1;
      held_time     <= '0;
      timer_running <= 1'b0;
      long_flag     <= 1'b0;
      last_level    <= 1'b1;
    end else if (step) begin
      since_edge    <= since_edge_next;
      held_time     <= held_time_next;
      timer_running <= timer_running_next;
      long_flag     <= long_flag_next;
      last_level    <= last_level_next;
    end
  end

endmodule

// ===== hdl/bdpc_out.sv =====
// ----------------------------------------------------------------------------
// bdpc_out
// Result register holding one classified release until it is taken.
// ----------------------------------------------------------------------------
module bdpc_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bdpc_pkg::key_idx_t load_button,
  input  logic               load_long,
  output logic               out_valid,
  input  logic               out_ready,
  output bdpc_pkg::key_idx_t pressed_button,
  output logic               is_long
);
  import bdpc_pkg::*;

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pressed_button <= load_button;
      is_long        <= load_long;
    end
  end

endmodule

// ===== hdl/button_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces four active-low buttons and reports each release as short or long.
// ----------------------------------------------------------------------------
//  channel  handshake            payload                         direction
//  input    in_valid/in_ready    op, button_index, pin_level     in
//  result   out_valid/out_ready  pressed_button, is_long         out
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data             in
//
//  One item per cycle unless stalled. An item is captured into an input
//  register; when it moves on, all key lanes update and any release result
//  is loaded into the result register.
//  Synchronous reset resets all key state and restores the register defaults.
//  The input register only stalls when it holds a release that produces a
//  result while the result register is full and not being taken.
//  The config port is always ready.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  bdpc_pkg::key_idx_t              button_index,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdpc_pkg::key_idx_t              pressed_button,
  output logic                            is_long,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdpc_pkg::*;

  logic              debounce_wr, long_wr;
  logic [DEB_W-1:0]  debounce_ms;
  logic [LONG_W-1:0] long_ms;

  logic     item_valid;
  logic     item_op;
  key_idx_t item_key;
  logic     item_level;
  logic     advance;
  logic     emit;
  logic     emit_long;

  key_cmd_t cmd [NUM_KEYS];
  key_res_t res [NUM_KEYS];

  assign cfg_ready   = 1'b1;
  assign debounce_wr = cfg_valid && (cfg_index == REG_DEBOUNCE);
  assign long_wr     = cfg_valid && (cfg_index == REG_LONG);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      long_ms     <= LONG_RESET;
    end else begin
      if (debounce_wr) begin
        debounce_ms <= cfg_data[DEB_W-1:0];
      end
      if (long_wr) begin
        long_ms <= cfg_data[LONG_W-1:0];
      end
    end
  end

  // the registered item moves on unless its result cannot be stored
  assign advance  = item_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op    <= op;
      item_key   <= button_index;
      item_level <= pin_level;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    always_comb begin
      cmd[k].tick     = item_valid && (item_op == OP_TICK);
      cmd[k].edge_hit = item_valid && (item_op == OP_EDGE) && (item_key == KEY_W'(k));
      cmd[k].level    = item_level;
    end

    bdpc_key u_key (
      .clk         (clk),
      .rst         (rst),
      .step        (advance),
      .cmd         (cmd[k]),
      .debounce_ms (debounce_ms),
      .long_ms     (long_ms),
      .res         (res[k])
    );
  end

  // only the addressed key can report, so a one-hot OR picks the result
  always_comb begin
    emit      = 1'b0;
    emit_long = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      emit      = emit | res[k].emit;
      emit_long = emit_long | (res[k].emit & res[k].is_long);
    end
  end

  bdpc_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (advance && emit),
    .load_button    (item_key),
    .load_long      (emit_long),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pressed_button (pressed_button),
    .is_long        (is_long)
  );

endmodule

// ===== hdl/bdpc_checker.sv =====
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks for the button debounce and press classifier.
// ----------------------------------------------------------------------------
module bdpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input bdpc_pkg::key_idx_t              pressed_button,
  input logic                            is_long,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import bdpc_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressed_button) && $stable(is_long))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pressed_button (pressed_button),
  .is_long        (is_long),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
